/* sv/obd_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and decode tables for the obd2 pid poll decoder
package obd_pkg;

    localparam int VAL_BITS  = 24;
    localparam int CFG_BITS  = 24;
    localparam int PID_COUNT = 7;

    localparam logic [10:0] RESP_ID_LO  = 11'h7E8;
    localparam logic [10:0] RESP_ID_HI  = 11'h7EF;
    localparam logic [7:0]  MODE01_RESP = 8'h41;

    localparam logic [7:0] PID_RPM      = 8'h0C;
    localparam logic [7:0] PID_SPEED    = 8'h0D;
    localparam logic [7:0] PID_COOLANT  = 8'h05;
    localparam logic [7:0] PID_INTAKE   = 8'h0F;
    localparam logic [7:0] PID_THROTTLE = 8'h11;
    localparam logic [7:0] PID_BOOST    = 8'h0B;
    localparam logic [7:0] PID_VOLTS    = 8'h42;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_SIGNAL  = 2'd2;

    localparam logic [2:0] SIG_RPM      = 3'd0;
    localparam logic [2:0] SIG_SPEED    = 3'd1;
    localparam logic [2:0] SIG_COOLANT  = 3'd2;
    localparam logic [2:0] SIG_INTAKE   = 3'd3;
    localparam logic [2:0] SIG_THROTTLE = 3'd4;
    localparam logic [2:0] SIG_BOOST    = 3'd5;
    localparam logic [2:0] SIG_VOLTS    = 3'd6;

    localparam logic [1:0] REG_ACTIVE_TIMEOUT     = 2'd0;
    localparam logic [1:0] REG_DRIVETRAIN_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_POLL_INTERVAL      = 2'd2;

    localparam logic [CFG_BITS-1:0] ACTIVE_TIMEOUT_RST     = 24'd2000000;
    localparam logic [CFG_BITS-1:0] DRIVETRAIN_TIMEOUT_RST = 24'd1500000;
    localparam logic [CFG_BITS-1:0] POLL_INTERVAL_RST      = 24'd80000;

    // volts: (32*word + 62) / 125 as multiply by ceil(2^29 / 125) and shift
    localparam logic [22:0] VOLT_RECIP = 23'd4294968;
    localparam int          VOLT_SHIFT = 29;
    localparam logic [21:0] VOLT_ROUND = 22'd62;

    typedef logic signed [VAL_BITS-1:0] value_t;
    typedef value_t lut_t [256];

    typedef struct packed {
        logic [CFG_BITS-1:0] active_timeout;
        logic [CFG_BITS-1:0] drivetrain_timeout;
        logic [CFG_BITS-1:0] poll_interval;
    } cfg_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
        value_t     value;
    } dec_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pid;
        logic [2:0] code;
        value_t     value;
        logic       active;
        logic       live;
    } res_t;

    function automatic logic [7:0] poll_pid(input logic [2:0] idx);
        logic [7:0] pid;
        unique case (idx)
            3'd0:    pid = PID_RPM;
            3'd1:    pid = PID_SPEED;
            3'd2:    pid = PID_COOLANT;
            3'd3:    pid = PID_INTAKE;
            3'd4:    pid = PID_THROTTLE;
            3'd5:    pid = PID_BOOST;
            3'd6:    pid = PID_VOLTS;
            default: pid = PID_RPM;
        endcase
        return pid;
    endfunction

    // (a-40)*9/5 + 32 in q15.8, rounded half away from zero
    function automatic lut_t build_temp_lut();
        lut_t   lut;
        longint n;
        longint q;
        for (int a = 0; a < 256; a++)
        begin
            n = longint'(a - 40) * 2304;
            if (n >= 0)
                q = (n + 2) / 5;
            else
                q = -((-n + 2) / 5);
            lut[a] = value_t'(q + 8192);
        end
        return lut;
    endfunction

    // a*100/255 in q15.8
    function automatic lut_t build_throttle_lut();
        lut_t   lut;
        longint q;
        for (int a = 0; a < 256; a++)
        begin
            q = (longint'(a) * 25600 + 127) / 255;
            lut[a] = value_t'(q);
        end
        return lut;
    endfunction

    // a*0.1450377 - 14.6959 psi in q15.8
    function automatic lut_t build_boost_lut();
        lut_t   lut;
        longint n;
        longint q;
        for (int a = 0; a < 256; a++)
        begin
            n = (longint'(a) * 1450377 - 146959000) * 256;
            if (n >= 0)
                q = (n + 5000000) / 10000000;
            else
                q = -((-n + 5000000) / 10000000);
            lut[a] = value_t'(q);
        end
        return lut;
    endfunction

endpackage

/* sv/obd_if.sv */
`timescale 1ns / 1ps
// item and result channel interfaces
interface obd_item_if #(parameter int TIME_BITS = 48);
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [TIME_BITS-1:0] time_now;
    logic [10:0]          frame_id;
    logic [7:0]           byte_zero;
    logic [7:0]           byte_one;
    logic [7:0]           byte_two;
    logic [7:0]           byte_three;
    logic [7:0]           byte_four;

    modport source (
        output valid, command, time_now, frame_id,
               byte_zero, byte_one, byte_two, byte_three, byte_four,
        input  ready
    );
    modport sink (
        input  valid, command, time_now, frame_id,
               byte_zero, byte_one, byte_two, byte_three, byte_four,
        output ready
    );
endinterface

interface obd_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic [7:0]         request_pid;
    logic [2:0]         signal_code;
    logic signed [23:0] signal_value;
    logic               polling_active;
    logic               drivetrain_live;

    modport source (
        output valid, result_kind, request_pid, signal_code, signal_value,
               polling_active, drivetrain_live,
        input  ready
    );
    modport sink (
        input  valid, result_kind, request_pid, signal_code, signal_value,
               polling_active, drivetrain_live,
        output ready
    );
endinterface

/* sv/obd_frame_dec.sv */
`timescale 1ns / 1ps
// mode-01 reply frame filter and pid value decoder
module obd_frame_dec (
    input  logic [10:0]  frame_id,
    input  logic [7:0]   byte_zero,
    input  logic [7:0]   byte_one,
    input  logic [7:0]   byte_two,
    input  logic [7:0]   byte_three,
    input  logic [7:0]   byte_four,
    output obd_pkg::dec_t dec
);
    import obd_pkg::*;

    localparam lut_t TEMP_LUT     = build_temp_lut();
    localparam lut_t THROTTLE_LUT = build_throttle_lut();
    localparam lut_t BOOST_LUT    = build_boost_lut();

    logic [15:0] word;
    logic [21:0] volt_num;
    logic [44:0] volt_prod;
    logic [15:0] volt_q;
    logic        frame_ok;

    assign word      = {byte_three, byte_four};
    assign volt_num  = {1'b0, word, 5'd0} + VOLT_ROUND;
    assign volt_prod = 45'(volt_num) * 45'(VOLT_RECIP);
    assign volt_q    = volt_prod[VOLT_SHIFT +: 16];

    assign frame_ok = (frame_id >= RESP_ID_LO) && (frame_id <= RESP_ID_HI)
                      && (byte_zero[7:4] == 4'd0) && (byte_one == MODE01_RESP);

    always_comb
    begin
        dec.hit   = frame_ok;
        dec.code  = SIG_RPM;
        dec.value = '0;
        unique case (byte_two)
            PID_RPM:
            begin
                dec.code  = SIG_RPM;
                dec.value = value_t'({2'd0, word, 6'd0});
            end
            PID_SPEED:
            begin
                dec.code  = SIG_SPEED;
                dec.value = value_t'({8'd0, byte_three, 8'd0});
            end
            PID_COOLANT:
            begin
                dec.code  = SIG_COOLANT;
                dec.value = TEMP_LUT[byte_three];
            end
            PID_INTAKE:
            begin
                dec.code  = SIG_INTAKE;
                dec.value = TEMP_LUT[byte_three];
            end
            PID_THROTTLE:
            begin
                dec.code  = SIG_THROTTLE;
                dec.value = THROTTLE_LUT[byte_three];
            end
            PID_BOOST:
            begin
                dec.code  = SIG_BOOST;
                dec.value = BOOST_LUT[byte_three];
            end
            PID_VOLTS:
            begin
                dec.code  = SIG_VOLTS;
                dec.value = value_t'({8'd0, volt_q});
            end
            default:
            begin
                dec.hit = 1'b0;
            end
        endcase
    end
endmodule

/* sv/obd_poll_state.sv */
`timescale 1ns / 1ps
// stamps, activity flag and poll cursor, with the per-item result logic
module obd_poll_state #(
    parameter int TIME_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 command,
    input  logic [TIME_BITS-1:0] time_now,
    input  obd_pkg::dec_t        dec,
    input  obd_pkg::cfg_t        cfg,
    output obd_pkg::res_t        res
);
    import obd_pkg::*;

    logic [TIME_BITS-1:0] rpm_stamp_reg, rpm_stamp_next;
    logic [TIME_BITS-1:0] speed_stamp_reg, speed_stamp_next;
    logic [TIME_BITS-1:0] reply_stamp_reg, reply_stamp_next;
    logic [TIME_BITS-1:0] request_stamp_reg, request_stamp_next;
    logic                 active_reg, active_next;
    logic [2:0]           cursor_reg, cursor_next;

    logic [TIME_BITS-1:0] reply_age;
    logic [TIME_BITS-1:0] request_age;
    logic                 active_kept;
    logic                 live_before;
    logic                 fire_req;
    logic                 take_frame;

    function automatic logic is_live(
        input logic [TIME_BITS-1:0] now,
        input logic [TIME_BITS-1:0] rpm_at,
        input logic [TIME_BITS-1:0] speed_at,
        input logic [CFG_BITS-1:0]  limit
    );
        logic [TIME_BITS-1:0] rpm_age;
        logic [TIME_BITS-1:0] speed_age;
        rpm_age   = now - rpm_at;
        speed_age = now - speed_at;
        return (rpm_at != '0) && (speed_at != '0)
               && (rpm_age <= TIME_BITS'(limit)) && (speed_age <= TIME_BITS'(limit));
    endfunction

    assign reply_age   = time_now - reply_stamp_reg;
    assign request_age = time_now - request_stamp_reg;
    assign active_kept = active_reg && (reply_age <= TIME_BITS'(cfg.active_timeout));
    assign live_before = is_live(time_now, rpm_stamp_reg, speed_stamp_reg,
                                 cfg.drivetrain_timeout);
    assign fire_req    = !command && (active_kept || !live_before)
                         && (request_age >= TIME_BITS'(cfg.poll_interval));
    assign take_frame  = command && dec.hit;

    always_comb
    begin
        rpm_stamp_next     = (take_frame && dec.code == SIG_RPM) ? time_now : rpm_stamp_reg;
        speed_stamp_next   = (take_frame && dec.code == SIG_SPEED) ? time_now : speed_stamp_reg;
        reply_stamp_next   = take_frame ? time_now : reply_stamp_reg;
        request_stamp_next = fire_req ? time_now : request_stamp_reg;
        active_next        = take_frame || active_kept;
        cursor_next        = cursor_reg;
        if (fire_req)
        begin
            if (cursor_reg >= 3'(PID_COUNT - 1))
                cursor_next = '0;
            else
                cursor_next = cursor_reg + 3'd1;
        end
    end

    always_comb
    begin
        res.kind   = KIND_NONE;
        res.pid    = '0;
        res.code   = '0;
        res.value  = '0;
        if (fire_req)
        begin
            res.kind = KIND_REQUEST;
            res.pid  = poll_pid(cursor_reg);
        end
        else if (take_frame)
        begin
            res.kind  = KIND_SIGNAL;
            res.code  = dec.code;
            res.value = dec.value;
        end
        res.active = active_next;
        res.live   = is_live(time_now, rpm_stamp_next, speed_stamp_next,
                             cfg.drivetrain_timeout);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_stamp_reg     <= '0;
            speed_stamp_reg   <= '0;
            reply_stamp_reg   <= '0;
            request_stamp_reg <= '0;
            active_reg        <= 1'b0;
            cursor_reg        <= '0;
        end
        else if (step)
        begin
            rpm_stamp_reg     <= rpm_stamp_next;
            speed_stamp_reg   <= speed_stamp_next;
            reply_stamp_reg   <= reply_stamp_next;
            request_stamp_reg <= request_stamp_next;
            active_reg        <= active_next;
            cursor_reg        <= cursor_next;
        end
    end
endmodule

/* sv/obd2_pid_poll_decoder_unit.sv */
`timescale 1ns / 1ps
// obd2 mode-01 pid poller and reply decoder, top level
//
// item channel: one poll tick or received standard can frame per item, with
// the current time in microseconds. result channel: exactly one result per
// item, in order: nothing, a pid request to send on 0x7DF, or a decoded
// signal in q15.8, plus the activity and drivetrain flags after the item.
// apb port: active timeout, drivetrain timeout and poll interval at byte
// addresses 0, 4 and 8; write only while no item is in flight.
// path: an item goes from the input register to the output register.
// throughput: one item per cycle unless the result stalls, set by the
// single registered pass through the frame decoder and the stamp compares.
// reset: registers return to their defaults, all stamps clear to never seen,
// activity off, poll cursor at rpm; both channels come up empty.
// stall: a result waits in the output register while ready is low; one more
// item is taken into the input register, then item ready drops until the
// result is taken.
module obd2_pid_poll_decoder_unit #(
    parameter int TIME_BITS = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    obd_item_if.sink           item,
    obd_result_if.source       result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import obd_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic                 stage_valid_reg, stage_valid_next;
    logic                 stage_command_reg;
    logic [TIME_BITS-1:0] stage_time_reg;
    logic [10:0]          stage_id_reg;
    logic [7:0]           stage_b0_reg;
    logic [7:0]           stage_b1_reg;
    logic [7:0]           stage_b2_reg;
    logic [7:0]           stage_b3_reg;
    logic [7:0]           stage_b4_reg;

    logic                 out_valid_reg, out_valid_next;
    res_t                 out_reg;

    logic                 item_fire;
    logic                 advance;
    logic                 cfg_write;
    logic [1:0]           reg_index;
    dec_t                 dec;
    res_t                 res;

    assign advance     = stage_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready  = !stage_valid_reg || advance;
    assign item_fire   = item.valid && item.ready;

    assign stage_valid_next = item_fire || (stage_valid_reg && !advance);
    assign out_valid_next   = advance || (out_valid_reg && !result.ready);

    obd_frame_dec u_frame_dec (
        .frame_id   (stage_id_reg),
        .byte_zero  (stage_b0_reg),
        .byte_one   (stage_b1_reg),
        .byte_two   (stage_b2_reg),
        .byte_three (stage_b3_reg),
        .byte_four  (stage_b4_reg),
        .dec        (dec)
    );

    obd_poll_state #(
        .TIME_BITS (TIME_BITS)
    ) u_poll_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .command  (stage_command_reg),
        .time_now (stage_time_reg),
        .dec      (dec),
        .cfg      (cfg_reg),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            stage_command_reg <= item.command;
            stage_time_reg    <= item.time_now;
            stage_id_reg      <= item.frame_id;
            stage_b0_reg      <= item.byte_zero;
            stage_b1_reg      <= item.byte_one;
            stage_b2_reg      <= item.byte_two;
            stage_b3_reg      <= item.byte_three;
            stage_b4_reg      <= item.byte_four;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.result_kind     = out_reg.kind;
    assign result.request_pid     = out_reg.pid;
    assign result.signal_code     = out_reg.code;
    assign result.signal_value    = out_reg.value;
    assign result.polling_active  = out_reg.active;
    assign result.drivetrain_live = out_reg.live;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                REG_ACTIVE_TIMEOUT:     cfg_next.active_timeout     = pwdata[CFG_BITS-1:0];
                REG_DRIVETRAIN_TIMEOUT: cfg_next.drivetrain_timeout = pwdata[CFG_BITS-1:0];
                REG_POLL_INTERVAL:      cfg_next.poll_interval      = pwdata[CFG_BITS-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_ACTIVE_TIMEOUT:     prdata = {8'd0, cfg_reg.active_timeout};
            REG_DRIVETRAIN_TIMEOUT: prdata = {8'd0, cfg_reg.drivetrain_timeout};
            REG_POLL_INTERVAL:      prdata = {8'd0, cfg_reg.poll_interval};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_timeout     <= ACTIVE_TIMEOUT_RST;
            cfg_reg.drivetrain_timeout <= DRIVETRAIN_TIMEOUT_RST;
            cfg_reg.poll_interval      <= POLL_INTERVAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

/* sv/obd_checker.sv */
`timescale 1ns / 1ps
// result channel checks for the obd2 pid poll decoder, bound to the top level
module obd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic [1:0]         res_kind,
    input logic [7:0]         res_pid,
    input logic [2:0]         res_code,
    input logic signed [23:0] res_value,
    input logic               res_active
);
    import obd_pkg::*;

    // a decoded signal always leaves activity on and carries no request
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_SIGNAL |-> res_active && res_pid == 8'd0)
        else $error("signal result without activity or with a pid");

    // a request names one of the polled pids and no signal fields
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_REQUEST |->
            (res_pid == PID_RPM || res_pid == PID_SPEED || res_pid == PID_COOLANT
             || res_pid == PID_INTAKE || res_pid == PID_THROTTLE
             || res_pid == PID_BOOST || res_pid == PID_VOLTS)
            && res_code == 3'd0 && res_value == 24'sd0)
        else $error("bad request result");

    // kind is never the unused code and an empty result is all zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_kind == KIND_NONE || res_kind == KIND_REQUEST
                       || res_kind == KIND_SIGNAL)
            && (res_kind != KIND_NONE
                || (res_pid == 8'd0 && res_code == 3'd0 && res_value == 24'sd0)))
        else $error("bad result kind or nonzero empty result");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_pid)
            && $stable(res_code) && $stable(res_value) && $stable(res_active))
        else $error("result changed while stalled");
endmodule

bind obd2_pid_poll_decoder_unit obd_checker u_obd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_kind   (result.result_kind),
    .res_pid    (result.request_pid),
    .res_code   (result.signal_code),
    .res_value  (result.signal_value),
    .res_active (result.polling_active)
);
